FILE: rtl/bmp_row_pixel_classifier_macros.svh
// Assertion helpers shared by the pixel classifier modules.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef BMP_ROW_PIXEL_CLASSIFIER_MACROS_SVH
`define BMP_ROW_PIXEL_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMP_RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BMP_RPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BMP_RPC_ASSERT(lbl, prop, msg)
`define BMP_RPC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/bmp_rpc_pkg.sv
package bmp_rpc_pkg;

  localparam int MAX_ROW_PIXELS_DEF  = 1024;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int DEPTH_W   = 3;
  localparam int PPR_W     = 11;
  localparam int BPR_W     = 13;
  localparam int RBC_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;
  localparam int COLUMN_W  = 10;
  localparam int RGB_W     = 16;
  localparam int PAL_W     = RGB_W + 2;
  localparam int ROW_BYTES_MAX = 4096;

  localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_2BPP  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd5;
  localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BPR       = 3'd5;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  typedef enum logic [1:0] {
    CLASS_WHITE   = 2'd0,
    CLASS_BLACK   = 2'd1,
    CLASS_COLORED = 2'd2,
    CLASS_KEEP    = 2'd3
  } pixel_class_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_PAL    = 2'd2,
    KIND_DIRECT = 2'd3
  } slot_kind_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               sixteen_565;
    logic               color_en;
    logic               multi;
    logic [PPR_W-1:0]   ppr;
    logic [BPR_W-1:0]   bpr;
  } cfg_t;

  typedef struct packed {
    slot_kind_e       kind;
    logic [7:0]       idx;
    logic [7:0]       data;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [RGB_W-1:0] color;
    logic             row_end;
  } slot_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic                row_done;
    logic                last;
    logic                is_pal;
    logic                oor;
    logic [RGB_W-1:0]    color;
    logic                white;
    logic                colored;
  } pix_t;

  function automatic logic use_color(cfg_t cfg);
    return cfg.color_en && (cfg.depth != DEPTH_1BPP);
  endfunction

  function automatic logic [RGB_W-1:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic is_whitish(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic uc);
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (uc) begin
      return (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
    end
    return sum > 10'd384;
  endfunction

  function automatic logic is_colored(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
  endfunction

endpackage

FILE: rtl/bmp_rpc_ram.sv
module bmp_rpc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bmp_rpc_unpack.sv
`include "bmp_row_pixel_classifier_macros.svh"

module bmp_rpc_unpack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmp_rpc_pkg::cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [7:0]        palette_index_i,
  input  logic [7:0]        entry_red_i,
  input  logic [7:0]        entry_green_i,
  input  logic [7:0]        entry_blue_i,
  input  logic [7:0]        data_byte_i,
  input  logic              pop_i,
  output logic              slot_valid_o,
  output bmp_rpc_pkg::slot_t slot_o
);

  logic [1:0]                    phase_q, phase_d;
  logic [7:0]                    held1_q, held1_d;
  logic [7:0]                    held2_q, held2_d;
  logic [7:0]                    held3_q, held3_d;
  logic [bmp_rpc_pkg::RBC_W-1:0] rbc_q, rbc_d;
  logic [bmp_rpc_pkg::BPR_W-1:0] bpr_sat;
  logic [bmp_rpc_pkg::BPR_W-1:0] rbc_inc;
  logic                          row_end;
  logic                          slot_valid_q;
  bmp_rpc_pkg::slot_t            slot_q, slot_d;
  logic                          accept;
  logic [1:0]                    final_phase;
  logic [7:0]                    lo, hi;

  assign in_ready_o = !slot_valid_q || pop_i;
  assign accept     = in_valid_i && in_ready_o;

  // zero reads as one byte, anything over the limit is clamped
  assign bpr_sat = (cfg_i.bpr == '0) ? bmp_rpc_pkg::BPR_W'(1) :
                   (cfg_i.bpr > bmp_rpc_pkg::BPR_W'(bmp_rpc_pkg::ROW_BYTES_MAX)) ?
                   bmp_rpc_pkg::BPR_W'(bmp_rpc_pkg::ROW_BYTES_MAX) : cfg_i.bpr;
  assign rbc_inc = {1'b0, rbc_q} + bmp_rpc_pkg::BPR_W'(1);
  assign row_end = rbc_inc >= bpr_sat;

  assign final_phase = (cfg_i.depth == bmp_rpc_pkg::DEPTH_24BPP) ? 2'd2 : 2'd3;
  assign lo = held1_q;
  assign hi = data_byte_i;

  always_comb begin
    phase_d       = phase_q;
    held1_d       = held1_q;
    held2_d       = held2_q;
    held3_d       = held3_q;
    rbc_d         = rbc_q;
    slot_d.kind   = bmp_rpc_pkg::KIND_NONE;
    slot_d.idx    = palette_index_i;
    slot_d.data   = data_byte_i;
    slot_d.red    = entry_red_i;
    slot_d.green  = entry_green_i;
    slot_d.blue   = entry_blue_i;
    slot_d.color  = '0;
    slot_d.row_end = 1'b0;
    if (mode_i == bmp_rpc_pkg::MODE_PALETTE) begin
      slot_d.kind = bmp_rpc_pkg::KIND_WRITE;
    end else begin
      priority if (cfg_i.depth <= bmp_rpc_pkg::DEPTH_8BPP) begin
        slot_d.kind = bmp_rpc_pkg::KIND_PAL;
      end else if (cfg_i.depth == bmp_rpc_pkg::DEPTH_16BPP) begin
        if (phase_q == 2'd0) begin
          held1_d = data_byte_i;
          phase_d = 2'd1;
        end else begin
          slot_d.kind = bmp_rpc_pkg::KIND_DIRECT;
          slot_d.blue = {lo[4:0], 3'b000};
          if (cfg_i.sixteen_565) begin
            slot_d.green = {hi[2:0], lo[7:5], 2'b00};
            slot_d.red   = {hi[7:3], 3'b000};
            slot_d.color = {hi, lo};
          end else begin
            slot_d.green = {hi[1:0], lo[7:5], 3'b000};
            slot_d.red   = {hi[6:2], 3'b000};
            slot_d.color = bmp_rpc_pkg::pack565({hi[6:2], 3'b000},
                                                {hi[1:0], lo[7:5], 3'b000},
                                                {lo[4:0], 3'b000});
          end
          phase_d = 2'd0;
        end
      end else if ((cfg_i.depth == bmp_rpc_pkg::DEPTH_24BPP) ||
                   (cfg_i.depth == bmp_rpc_pkg::DEPTH_32BPP)) begin
        priority if (phase_q == 2'd0) begin
          held1_d = data_byte_i;
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          held2_d = data_byte_i;
          phase_d = 2'd2;
        end else if (phase_q < final_phase) begin
          held3_d = data_byte_i;
          phase_d = 2'd3;
        end else begin
          slot_d.kind  = bmp_rpc_pkg::KIND_DIRECT;
          slot_d.blue  = held1_q;
          slot_d.green = held2_q;
          slot_d.red   = (cfg_i.depth == bmp_rpc_pkg::DEPTH_24BPP) ? data_byte_i : held3_q;
          slot_d.color = bmp_rpc_pkg::pack565(slot_d.red, held2_q, held1_q);
          phase_d      = 2'd0;
        end
      end else begin
        slot_d.kind = bmp_rpc_pkg::KIND_NONE;
      end
      slot_d.row_end = row_end;
      if (row_end) begin
        rbc_d   = '0;
        phase_d = 2'd0;
      end else begin
        rbc_d = rbc_inc[bmp_rpc_pkg::RBC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 2'd0;
      held1_q      <= '0;
      held2_q      <= '0;
      held3_q      <= '0;
      rbc_q        <= '0;
      slot_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        held1_q      <= held1_d;
        held2_q      <= held2_d;
        held3_q      <= held3_d;
        rbc_q        <= rbc_d;
        slot_valid_q <= 1'b1;
      end else if (pop_i) begin
        slot_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= slot_d;
    end
  end

  assign slot_valid_o = slot_valid_q;
  assign slot_o       = slot_q;

  `BMP_RPC_ASSERT_NEXT(a_accept_fills_slot, accept, slot_valid_q,
                       "accepted transaction did not reach the slot")

endmodule

FILE: rtl/bmp_rpc_issue.sv
`include "bmp_row_pixel_classifier_macros.svh"

module bmp_rpc_issue #(
  parameter int MAX_ROW_PIXELS  = bmp_rpc_pkg::MAX_ROW_PIXELS_DEF,
  parameter int PALETTE_ENTRIES = bmp_rpc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmp_rpc_pkg::cfg_t               cfg_i,
  input  logic                            slot_valid_i,
  input  bmp_rpc_pkg::slot_t              slot_i,
  input  logic                            advance_i,
  output logic                            pop_o,
  output logic                            pix_valid_o,
  output bmp_rpc_pkg::pix_t               pix_o,
  output logic [bmp_rpc_pkg::PAL_W-1:0]   pal_rdata_o
);

  localparam int COL_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [COL_W-1:0]  col_q, col_inc, ppr_sat;
  logic [2:0]        k_q, last_k, sh;
  logic [7:0]        shifted, pn;
  logic              col_lt, row_done, final_step, go, emit, last, oor, uc;
  logic              ram_we, ram_re, idx_ok;
  logic              pix_valid_q;
  bmp_rpc_pkg::pix_t pix_q, pix_d;

  assign uc = bmp_rpc_pkg::use_color(cfg_i);

  assign ppr_sat = (32'(cfg_i.ppr) > 32'(MAX_ROW_PIXELS)) ? COL_W'(MAX_ROW_PIXELS) :
                   COL_W'(cfg_i.ppr);
  assign col_lt   = col_q < ppr_sat;
  assign col_inc  = col_q + COL_W'(1);
  assign row_done = col_inc == ppr_sat;

  always_comb begin
    unique case (cfg_i.depth[1:0])
      2'd0:    last_k = 3'd7;
      2'd1:    last_k = 3'd3;
      2'd2:    last_k = 3'd1;
      default: last_k = 3'd0;
    endcase
  end

  assign final_step = k_q == last_k;
  assign sh         = k_q << cfg_i.depth[1:0];
  assign shifted    = slot_i.data << sh;

  always_comb begin
    unique case (cfg_i.depth[1:0])
      2'd0:    pn = {7'b0, shifted[7]};
      2'd1:    pn = {6'b0, shifted[7:6]};
      2'd2:    pn = {4'b0, shifted[7:4]};
      default: pn = shifted;
    endcase
  end

  assign oor    = {1'b0, pn} >= 9'(PALETTE_ENTRIES);
  assign idx_ok = {1'b0, slot_i.idx} < 9'(PALETTE_ENTRIES);
  assign go     = slot_valid_i && advance_i;

  always_comb begin
    emit   = 1'b0;
    pop_o  = 1'b0;
    last   = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    unique case (slot_i.kind)
      bmp_rpc_pkg::KIND_WRITE: begin
        pop_o  = go;
        ram_we = go && idx_ok;
      end
      bmp_rpc_pkg::KIND_PAL: begin
        if (col_lt) begin
          last   = final_step || row_done;
          emit   = go;
          ram_re = go && !oor;
          pop_o  = go && last;
        end else begin
          pop_o = go;
        end
      end
      bmp_rpc_pkg::KIND_DIRECT: begin
        last  = 1'b1;
        emit  = go && col_lt;
        pop_o = go;
      end
      default: begin
        pop_o = go;
      end
    endcase
  end

  always_comb begin
    pix_d.column   = bmp_rpc_pkg::COLUMN_W'(col_q);
    pix_d.row_done = row_done;
    pix_d.last     = last;
    pix_d.is_pal   = slot_i.kind == bmp_rpc_pkg::KIND_PAL;
    pix_d.oor      = oor;
    pix_d.color    = slot_i.color;
    pix_d.white    = bmp_rpc_pkg::is_whitish(slot_i.red, slot_i.green, slot_i.blue, uc);
    pix_d.colored  = bmp_rpc_pkg::is_colored(slot_i.red, slot_i.green, slot_i.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      k_q         <= 3'd0;
      pix_valid_q <= 1'b0;
    end else begin
      if (pop_o && slot_i.row_end) begin
        col_q <= '0;
      end else if (emit) begin
        col_q <= col_inc;
      end
      if (pop_o) begin
        k_q <= 3'd0;
      end else if (emit) begin
        k_q <= k_q + 3'd1;
      end
      if (advance_i) begin
        pix_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pix_q <= pix_d;
    end
  end

  bmp_rpc_ram #(
    .WIDTH (bmp_rpc_pkg::PAL_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_i.idx[PAL_AW-1:0]),
    .wdata_i ({bmp_rpc_pkg::pack565(slot_i.red, slot_i.green, slot_i.blue),
               pix_d.white, pix_d.colored}),
    .re_i    (ram_re),
    .raddr_i (pn[PAL_AW-1:0]),
    .rdata_o (pal_rdata_o)
  );

  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

  `BMP_RPC_ASSERT_NEXT(a_row_end_clears_column, pop_o && slot_i.row_end, col_q == '0,
                       "column not cleared at row end")
  `BMP_RPC_ASSERT(a_no_write_with_read, !(ram_we && ram_re),
                  "palette write and read issued together")

endmodule

FILE: rtl/bmp_rpc_classify.sv
`include "bmp_row_pixel_classifier_macros.svh"

module bmp_rpc_classify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmp_rpc_pkg::cfg_t             cfg_i,
  input  logic                          pix_valid_i,
  input  bmp_rpc_pkg::pix_t             pix_i,
  input  logic [bmp_rpc_pkg::PAL_W-1:0] pal_rdata_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   out_data_o,
  output logic                          out_last_o
);

  logic                                 uc, white, colored;
  logic [bmp_rpc_pkg::RGB_W-1:0]        color;
  bmp_rpc_pkg::pixel_class_e            cls;
  logic                                 valid_q;
  logic [bmp_rpc_pkg::COLUMN_W-1:0]     column_q;
  logic [bmp_rpc_pkg::RGB_W-1:0]        rgb_q;
  bmp_rpc_pkg::pixel_class_e            cls_q;
  logic                                 row_done_q, last_q;

  assign uc        = bmp_rpc_pkg::use_color(cfg_i);
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    if (!pix_i.is_pal) begin
      color   = pix_i.color;
      white   = pix_i.white;
      colored = pix_i.colored;
    end else if (pix_i.oor) begin
      color   = '0;
      white   = 1'b0;
      colored = 1'b0;
    end else begin
      color   = pal_rdata_i[bmp_rpc_pkg::PAL_W-1:2];
      white   = pal_rdata_i[1];
      colored = pal_rdata_i[0];
    end
  end

  always_comb begin
    priority if (uc && cfg_i.multi) begin
      cls = bmp_rpc_pkg::CLASS_KEEP;
    end else if (white) begin
      cls = bmp_rpc_pkg::CLASS_WHITE;
    end else if (colored && uc) begin
      cls = bmp_rpc_pkg::CLASS_COLORED;
    end else begin
      cls = bmp_rpc_pkg::CLASS_BLACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      column_q   <= pix_i.column;
      rgb_q      <= color;
      cls_q      <= cls;
      row_done_q <= pix_i.row_done;
      last_q     <= pix_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {3'b000, row_done_q, cls_q, rgb_q, column_q};
  assign out_last_o  = last_q;

  `BMP_RPC_ASSERT(a_row_done_is_last, (valid_q && row_done_q) |-> last_q,
                  "row end pixel not marked last")

endmodule

FILE: rtl/bmp_row_pixel_classifier.sv
// Latency: the first pixel of a transaction is held in the slot, pixel and output registers in turn.
// Throughput: one transaction per cycle at 8, 16, 24 and 32 bits per pixel unless the output
// stalls; at 1, 2 and 4 bits a byte holds the issue stage while it yields its visible pixels
// (up to 8) at one per cycle, set by the single palette read port.
// Reset: asynchronous, active low; control state and configuration return to defaults,
// palette contents are undefined until written.
module bmp_row_pixel_classifier #(
  parameter int MAX_ROW_PIXELS  = bmp_rpc_pkg::MAX_ROW_PIXELS_DEF,
  parameter int PALETTE_ENTRIES = bmp_rpc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmp_rpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bmp_rpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // palette_index, entry_red, entry_green, entry_blue, data_byte
  input  logic [39:0]                       s_axis_tdata_i,
  // mode
  input  logic [0:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // column, rgb565, pixel_class, row_done, zero fill
  output logic [31:0]                       m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);

  bmp_rpc_pkg::cfg_t             cfg_q;
  logic                          slot_valid, pop, pix_valid, advance;
  bmp_rpc_pkg::slot_t            slot;
  bmp_rpc_pkg::pix_t             pix;
  logic [bmp_rpc_pkg::PAL_W-1:0] pal_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth       <= bmp_rpc_pkg::DEPTH_24BPP;
      cfg_q.sixteen_565 <= 1'b0;
      cfg_q.color_en    <= 1'b0;
      cfg_q.multi       <= 1'b0;
      cfg_q.ppr         <= bmp_rpc_pkg::PPR_W'(1);
      cfg_q.bpr         <= bmp_rpc_pkg::BPR_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmp_rpc_pkg::CFG_DEPTH:    cfg_q.depth       <= cfg_wdata_i[bmp_rpc_pkg::DEPTH_W-1:0];
        bmp_rpc_pkg::CFG_SIXTEEN:  cfg_q.sixteen_565 <= cfg_wdata_i[0];
        bmp_rpc_pkg::CFG_COLOR_EN: cfg_q.color_en    <= cfg_wdata_i[0];
        bmp_rpc_pkg::CFG_MULTI:    cfg_q.multi       <= cfg_wdata_i[0];
        bmp_rpc_pkg::CFG_PPR:      cfg_q.ppr         <= cfg_wdata_i[bmp_rpc_pkg::PPR_W-1:0];
        bmp_rpc_pkg::CFG_BPR:      cfg_q.bpr         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bmp_rpc_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .mode_i          (s_axis_tuser_i[0]),
    .palette_index_i (s_axis_tdata_i[7:0]),
    .entry_red_i     (s_axis_tdata_i[15:8]),
    .entry_green_i   (s_axis_tdata_i[23:16]),
    .entry_blue_i    (s_axis_tdata_i[31:24]),
    .data_byte_i     (s_axis_tdata_i[39:32]),
    .pop_i           (pop),
    .slot_valid_o    (slot_valid),
    .slot_o          (slot)
  );

  bmp_rpc_issue #(
    .MAX_ROW_PIXELS  (MAX_ROW_PIXELS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .slot_valid_i (slot_valid),
    .slot_i       (slot),
    .advance_i    (advance),
    .pop_o        (pop),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix),
    .pal_rdata_o  (pal_rdata)
  );

  bmp_rpc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .pal_rdata_i (pal_rdata),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
